>>> hw/rtl/fork_id_crc_and_compat_check_defines.svh
// assertion macros for the fork id crc block
// no dependencies; included by the checker file
`ifndef FORK_ID_CRC_AND_COMPAT_CHECK_DEFINES_SVH
`define FORK_ID_CRC_AND_COMPAT_CHECK_DEFINES_SVH

// assertion sampled on the rising clock edge, switched off while reset is low
`define FIDCRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that also holds while reset is low
`define FIDCRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fidcrc_pkg.sv
// shared types, codes and crc-32 functions for the fork id crc block
// no dependencies; imported by every module of the block
package fidcrc_pkg;

  // operation codes on the input tuser
  localparam logic [1:0] OP_GENESIS = 2'd0;
  localparam logic [1:0] OP_FORK    = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_REMOTE_HASH = 2'd0;
  localparam logic [1:0] CFG_REMOTE_NEXT = 2'd1;
  localparam logic [1:0] CFG_HEAD_BLOCK  = 2'd2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int InDataW  = 72;   // data_byte, fork_pos
  localparam int OutDataW = 104;  // local_hash, local_next, compatible, zero fill
  localparam int OutUsedW = 97;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  typedef enum logic [1:0] {
    KIND_GENESIS,
    KIND_FORK,
    KIND_FINISH
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] payload;  // genesis byte in the low bits, or fork point
  } entry_t;

  // one byte through the reflected crc register (raw, not inverted)
  function automatic logic [31:0] crc_byte(input logic [31:0] raw, input logic [7:0] b);
    logic [31:0] r;
    r = raw ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_add_byte(input logic [31:0] crc, input logic [7:0] b);
    return ~crc_byte(~crc, b);
  endfunction

  // fork point as eight big-endian bytes; linear in the data, so a flat xor net
  function automatic logic [31:0] crc_add_u64(input logic [31:0] crc, input logic [63:0] v);
    logic [31:0] r;
    r = ~crc;
    for (int i = 7; i >= 0; i--) begin
      r = crc_byte(r, v[8*i +: 8]);
    end
    return ~r;
  endfunction

endpackage

>>> hw/rtl/fidcrc_front.sv
// front stage: accepts input words, decodes the operation, drops unused codes
// depends on fidcrc_pkg
module fidcrc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fidcrc_pkg::InDataW-1:0] s_axis_tdata,  // data_byte, fork_pos
  input  logic [1:0]                    s_axis_tuser,  // operation
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output fidcrc_pkg::entry_t            push_entry_o
);
  import fidcrc_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   keep;
  entry_t decoded;

  always_comb begin
    keep            = 1'b1;
    decoded.kind    = KIND_GENESIS;
    decoded.payload = {56'd0, s_axis_tdata[7:0]};
    unique case (s_axis_tuser)
      OP_GENESIS: decoded.kind = KIND_GENESIS;
      OP_FORK: begin
        decoded.kind    = KIND_FORK;
        decoded.payload = s_axis_tdata[71:8];
      end
      OP_FINISH: decoded.kind = KIND_FINISH;
      default: keep = 1'b0;
    endcase
  end

  assign s_axis_tready = !valid_q || push_ready_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid && keep;
      entry_d = decoded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

>>> hw/rtl/fidcrc_queue.sv
// short first-in first-out queue of decoded words between front and back
// depends on fidcrc_pkg
module fidcrc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  fidcrc_pkg::entry_t push_entry_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output fidcrc_pkg::entry_t pop_entry_o
);
  import fidcrc_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = count_q != QCntW'(QDepth);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> hw/rtl/fidcrc_back.sv
// back stage: crc state, fork bookkeeping, compatibility verdict, result register
// depends on fidcrc_pkg
module fidcrc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fidcrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fidcrc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  fidcrc_pkg::entry_t              pop_entry_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fidcrc_pkg::OutDataW-1:0] m_axis_tdata
);
  import fidcrc_pkg::*;

  // configuration
  logic [31:0] remote_hash_q;
  logic [63:0] remote_next_q, head_block_q;

  // chain state
  logic [31:0] run_crc_q, run_crc_d;
  logic [31:0] held_hash_q, held_hash_d;
  logic        gen_done_q, gen_done_d;
  logic        next_found_q, next_found_d;
  logic [63:0] held_next_q, held_next_d;
  logic        common_found_q, common_found_d;
  logic [63:0] common_point_q, common_point_d;
  logic        after_valid_q, after_valid_d;
  logic [63:0] after_point_q, after_point_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q, out_hash_d;
  logic [63:0] out_next_q, out_next_d;
  logic        out_compat_q, out_compat_d;

  logic        out_free, do_pop;
  logic        close_cf, before_head, verdict;
  logic [63:0] fork_val;
  logic [7:0]  gbyte;
  logic [31:0] fork_crc, hash_fork_crc;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign pop_ready_o = (pop_entry_i.kind != KIND_FINISH) || out_free;
  assign do_pop      = pop_valid_i && pop_ready_o;

  assign fork_val      = pop_entry_i.payload;
  assign gbyte         = pop_entry_i.payload[7:0];
  assign fork_crc      = crc_add_u64(run_crc_q, fork_val);
  assign hash_fork_crc = crc_add_u64(held_hash_q, fork_val);

  // genesis match counts once genesis closes; point stays zero in that case
  assign close_cf    = common_found_q || (!gen_done_q && run_crc_q == remote_hash_q);
  assign before_head = after_valid_q && (after_point_q <= head_block_q);
  assign verdict     = close_cf &&
                       ((head_block_q < common_point_q) ||
                        (before_head && remote_next_q == after_point_q) ||
                        (!before_head && (remote_next_q == '0 ||
                                          remote_next_q > head_block_q)));

  always_comb begin
    run_crc_d      = run_crc_q;
    held_hash_d    = held_hash_q;
    gen_done_d     = gen_done_q;
    next_found_d   = next_found_q;
    held_next_d    = held_next_q;
    common_found_d = common_found_q;
    common_point_d = common_point_q;
    after_valid_d  = after_valid_q;
    after_point_d  = after_point_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_hash_d     = out_hash_q;
    out_next_d     = out_next_q;
    out_compat_d   = out_compat_q;
    if (do_pop) begin
      unique case (pop_entry_i.kind)
        KIND_GENESIS: begin
          if (!gen_done_q) begin
            run_crc_d   = crc_add_byte(run_crc_q, gbyte);
            held_hash_d = crc_add_byte(held_hash_q, gbyte);
          end
        end
        KIND_FORK: begin
          gen_done_d     = 1'b1;
          common_found_d = close_cf;
          if (close_cf) begin
            if (!after_valid_q) begin
              after_valid_d = 1'b1;
              after_point_d = fork_val;
            end
          end else begin
            run_crc_d = fork_crc;
            if (fork_crc == remote_hash_q) begin
              common_found_d = 1'b1;
              common_point_d = fork_val;
            end
          end
          if (!next_found_q) begin
            if (fork_val > head_block_q) begin
              next_found_d = 1'b1;
              held_next_d  = fork_val;
            end else begin
              held_hash_d = hash_fork_crc;
            end
          end
        end
        KIND_FINISH: begin
          out_valid_d    = 1'b1;
          out_hash_d     = held_hash_q;
          out_next_d     = next_found_q ? held_next_q : '0;
          out_compat_d   = verdict;
          run_crc_d      = '0;
          held_hash_d    = '0;
          gen_done_d     = 1'b0;
          next_found_d   = 1'b0;
          held_next_d    = '0;
          common_found_d = 1'b0;
          common_point_d = '0;
          after_valid_d  = 1'b0;
          after_point_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_hash_q  <= '0;
      remote_next_q  <= '0;
      head_block_q   <= '0;
      run_crc_q      <= '0;
      held_hash_q    <= '0;
      gen_done_q     <= 1'b0;
      next_found_q   <= 1'b0;
      held_next_q    <= '0;
      common_found_q <= 1'b0;
      common_point_q <= '0;
      after_valid_q  <= 1'b0;
      after_point_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_REMOTE_HASH: remote_hash_q <= cfg_wdata_i[31:0];
          CFG_REMOTE_NEXT: remote_next_q <= cfg_wdata_i;
          CFG_HEAD_BLOCK:  head_block_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      run_crc_q      <= run_crc_d;
      held_hash_q    <= held_hash_d;
      gen_done_q     <= gen_done_d;
      next_found_q   <= next_found_d;
      held_next_q    <= held_next_d;
      common_found_q <= common_found_d;
      common_point_q <= common_point_d;
      after_valid_q  <= after_valid_d;
      after_point_q  <= after_point_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q   <= out_hash_d;
    out_next_q   <= out_next_d;
    out_compat_q <= out_compat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_compat_q, out_next_q, out_hash_q};

endmodule

>>> hw/rtl/fork_id_crc_and_compat_check.sv
// fork identifier builder: reflected crc-32 over genesis bytes and fork points,
// local hash and next fork, and a compatibility verdict against a remote id.
// Words enter with the operation on tuser (genesis byte, fork point, finish) and
// are taken one per clock, back to back, while the queue has room. A front
// register decodes each word and drops the unused operation code; a four-word
// queue decouples it from the back stage, which updates the crc state for each
// word (a flat 64-bit xor network for a fork point) and writes the result into
// an output register. A finish word passes through the front register and the
// queue before it reaches that register; only a finish word waits for a full
// output register, and the queue keeps input flowing meanwhile. After a finish
// the chain state is cleared for the next run, while the configuration registers
// keep their values. Write the configuration only with no word in flight.
module fork_id_crc_and_compat_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [fidcrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fidcrc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [fidcrc_pkg::InDataW-1:0]  s_axis_tdata,  // data_byte [7:0], fork_pos [71:8]
  input  logic [1:0]                      s_axis_tuser,  // operation
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fidcrc_pkg::OutDataW-1:0] m_axis_tdata   // local_hash [31:0],
                                                         // local_next [95:32],
                                                         // compatible [96], zeros above
);
  import fidcrc_pkg::*;

  // front to queue
  logic   push_valid, push_ready;
  entry_t push_entry;
  // queue to back
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  fidcrc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  // absorbs the back stage stalling on a full result register
  fidcrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  fidcrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_entry_i   (pop_entry),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/fidcrc_checker.sv
// port-level checker for the fork id crc block, bound to the top level
// depends on fidcrc_pkg and fork_id_crc_and_compat_check_defines.svh
`include "fork_id_crc_and_compat_check_defines.svh"

module fidcrc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fidcrc_pkg::OutDataW-1:0] m_axis_tdata
);
  import fidcrc_pkg::*;

  // a result word stays offered until taken
  `FIDCRC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result word dropped while stalled")

  // a stalled result word keeps its value
  `FIDCRC_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result word changed while stalled")

  // fill bits above the compatible flag are zero
  `FIDCRC_ASSERT(a_out_fill, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OutUsedW] == '0, "nonzero fill bits in result word")

  // reset empties the pipe: no result and room for input
  `FIDCRC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid && s_axis_tready, "block not idle after reset")

endmodule

bind fork_id_crc_and_compat_check fidcrc_checker u_fidcrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
